### rtl/core/byte_stream_hash_little_endian_macros.svh
// Assertion macros for the byte stream hash core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BYTE_STREAM_HASH_LITTLE_ENDIAN_MACROS_SVH
`define BYTE_STREAM_HASH_LITTLE_ENDIAN_MACROS_SVH

`ifndef SYNTHESIS
// Check that is held off while reset is asserted.
`define BSHL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that is evaluated at every clock edge.
`define BSHL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSHL_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSHL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/bshl_pkg.sv
// Shared types, constants and mixing helpers of the byte stream hash core.
// No dependencies; used by every module of the core.
package bshl_pkg;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_fill;
    typedef logic [2:0]  t_step;

    localparam t_word HASH_INIT       = 32'hdeadbeef;
    localparam t_fill BLOCK_BYTES     = 4'd12;
    localparam t_step BLOCK_LAST_STEP = 3'd5;
    localparam t_step FINAL_LAST_STEP = 3'd6;
    localparam int    QUEUE_DEPTH_DEF = 4;

    // Input word of the byte channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        t_word      msg_length;
    } t_in_word;

    // Result word of the hash channel.
    typedef struct packed {
        t_word hash_value;
        logic  length_mismatch;
    } t_out_word;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        t_word      init_value;
        logic       mismatch;
    } t_cmd;

    // Mixer state of the back end.
    typedef enum logic [2:0] {
        MIX_IDLE  = 3'b001,
        MIX_BLOCK = 3'b010,
        MIX_FINAL = 3'b100
    } t_mix_mode;

    // Rotate left by a nonzero amount.
    function automatic t_word rotl(input t_word x, input logic [4:0] k);
        logic [63:0] w;
        w = {x, x} << k;
        return w[63:32];
    endfunction

endpackage

### rtl/core/bshl_front.sv
// Front end: holds the seed, accepts input words, drops bytes outside a message,
// tracks the byte count and builds the command for the back end. Uses bshl_pkg.
module bshl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  bshl_pkg::t_word    i_cfg_data,
    input  logic               i_in_valid,
    input  bshl_pkg::t_in_word i_in_word,
    input  logic               i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output bshl_pkg::t_cmd     o_cmd
);
    import bshl_pkg::*;

    t_word r_seed, n_seed;
    logic  r_in_message, n_in_message;
    t_word r_bytes_seen, n_bytes_seen;
    t_word r_declared, n_declared;
    logic  accept;

    // The queue being full is the only reason to hold the source off.
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept && (i_in_word.first_byte || r_in_message);

    // Classify the word and update the message bookkeeping.
    always_comb begin
        n_seed       = r_seed;
        n_in_message = r_in_message;
        n_bytes_seen = r_bytes_seen;
        n_declared   = r_declared;
        if (i_cfg_valid) begin
            n_seed = i_cfg_data;
        end
        if (i_in_word.first_byte) begin
            n_declared   = i_in_word.msg_length;
            n_bytes_seen = 32'd1;
        end else if (r_bytes_seen != '1) begin
            n_bytes_seen = r_bytes_seen + 32'd1;
        end
        n_in_message = !i_in_word.last_byte;

        o_cmd.data_byte  = i_in_word.data_byte;
        o_cmd.first_byte = i_in_word.first_byte;
        o_cmd.last_byte  = i_in_word.last_byte;
        o_cmd.init_value = HASH_INIT + i_in_word.msg_length + r_seed;
        o_cmd.mismatch   = (n_bytes_seen != n_declared);
    end

    // Seed and message state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_in_message <= 1'b0;
            r_bytes_seen <= '0;
            r_declared   <= '0;
        end else begin
            r_seed <= n_seed;
            if (o_push) begin
                r_in_message <= n_in_message;
                r_bytes_seen <= n_bytes_seen;
                r_declared   <= n_declared;
            end
        end
    end

endmodule

### rtl/core/bshl_queue.sv
// Small command queue between the front and the back end.
// Uses bshl_pkg for the command type.
module bshl_queue #(
    parameter int DEPTH = bshl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bshl_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output bshl_pkg::t_cmd o_head
);
    import bshl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and count updates with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Storage is written without reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/core/bshl_back.sv
// Back end: gathers bytes into a 12-byte block buffer, runs the block and final
// mixing rounds one per cycle on the three lanes, and holds the result word; the
// last final round waits for a free result. Uses bshl_pkg and the assertion macros.
`include "byte_stream_hash_little_endian_macros.svh"

module bshl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  bshl_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output bshl_pkg::t_out_word o_out_word
);
    import bshl_pkg::*;

    t_word            r_a, n_a, r_b, n_b, r_c, n_c;
    t_word            m_a, m_b, m_c;
    logic [11:0][7:0] r_blk, n_blk;
    t_fill            r_fill, n_fill;
    t_mix_mode        r_mode, n_mode;
    t_step            r_step, n_step;
    logic             r_fin_pend, n_fin_pend;
    logic             r_fin_mis, n_fin_mis;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word, n_out_word;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A byte that needs the lanes waits for an idle mixer; plain bytes go on unless a close is pending.
    assign o_pop = i_q_valid && !r_fin_pend &&
                   (r_mode == MIX_IDLE || (!i_cmd.first_byte && r_fill != BLOCK_BYTES));

    // One mixing round per cycle, selected by mode and step.
    always_comb begin
        m_a = r_a;
        m_b = r_b;
        m_c = r_c;
        if (r_mode == MIX_BLOCK) begin
            unique case (r_step)
                3'd0: begin m_a = (r_a - r_c) ^ rotl(r_c, 5'd4);  m_c = r_c + r_b; end
                3'd1: begin m_b = (r_b - r_a) ^ rotl(r_a, 5'd6);  m_a = r_a + r_c; end
                3'd2: begin m_c = (r_c - r_b) ^ rotl(r_b, 5'd8);  m_b = r_b + r_a; end
                3'd3: begin m_a = (r_a - r_c) ^ rotl(r_c, 5'd16); m_c = r_c + r_b; end
                3'd4: begin m_b = (r_b - r_a) ^ rotl(r_a, 5'd19); m_a = r_a + r_c; end
                3'd5: begin m_c = (r_c - r_b) ^ rotl(r_b, 5'd4);  m_b = r_b + r_a; end
                default: begin end
            endcase
        end else begin
            unique case (r_step)
                3'd0: m_c = (r_c ^ r_b) - rotl(r_b, 5'd14);
                3'd1: m_a = (r_a ^ r_c) - rotl(r_c, 5'd11);
                3'd2: m_b = (r_b ^ r_a) - rotl(r_a, 5'd25);
                3'd3: m_c = (r_c ^ r_b) - rotl(r_b, 5'd16);
                3'd4: m_a = (r_a ^ r_c) - rotl(r_c, 5'd4);
                3'd5: m_b = (r_b ^ r_a) - rotl(r_a, 5'd14);
                3'd6: m_c = (r_c ^ r_b) - rotl(r_b, 5'd24);
                default: begin end
            endcase
        end
    end

    // Lane, block buffer and sequencing updates.
    always_comb begin
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_blk       = r_blk;
        n_fill      = r_fill;
        n_mode      = r_mode;
        n_step      = r_step;
        n_fin_pend  = r_fin_pend;
        n_fin_mis   = r_fin_mis;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_mode)
            MIX_BLOCK: begin
                n_a = m_a;
                n_b = m_b;
                n_c = m_c;
                if (r_step == BLOCK_LAST_STEP) begin
                    n_mode = MIX_IDLE;
                    n_step = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            MIX_FINAL: begin
                if (r_step == FINAL_LAST_STEP) begin
                    if (out_free) begin
                        n_out_valid                = 1'b1;
                        n_out_word.hash_value      = m_c;
                        n_out_word.length_mismatch = r_fin_mis;
                        n_mode                     = MIX_IDLE;
                        n_step                     = '0;
                    end
                end else begin
                    n_a    = m_a;
                    n_b    = m_b;
                    n_c    = m_c;
                    n_step = r_step + 1'b1;
                end
            end
            MIX_IDLE: begin
                // Closing a message: add the open block and start the final rounds.
                if (r_fin_pend) begin
                    n_a        = r_a + r_blk[3:0];
                    n_b        = r_b + r_blk[7:4];
                    n_c        = r_c + r_blk[11:8];
                    n_mode     = MIX_FINAL;
                    n_step     = '0;
                    n_fin_pend = 1'b0;
                end
            end
            default: begin
                n_mode = MIX_IDLE;
            end
        endcase

        // Take one byte from the queue.
        if (o_pop) begin
            if (i_cmd.first_byte) begin
                n_a    = i_cmd.init_value;
                n_b    = i_cmd.init_value;
                n_c    = i_cmd.init_value;
                n_blk  = '0;
                n_blk[0] = i_cmd.data_byte;
                n_fill = 4'd1;
            end else if (r_fill == BLOCK_BYTES) begin
                // Full block followed by another byte: fold it in and mix.
                n_a    = r_a + r_blk[3:0];
                n_b    = r_b + r_blk[7:4];
                n_c    = r_c + r_blk[11:8];
                n_mode = MIX_BLOCK;
                n_step = '0;
                n_blk  = '0;
                n_blk[0] = i_cmd.data_byte;
                n_fill = 4'd1;
            end else begin
                n_blk[r_fill] = i_cmd.data_byte;
                n_fill        = r_fill + 1'b1;
            end
            if (i_cmd.last_byte) begin
                n_fin_pend = 1'b1;
                n_fin_mis  = i_cmd.mismatch;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_blk      <= n_blk;
        r_fin_mis  <= n_fin_mis;
        r_out_word <= n_out_word;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_mode      <= MIX_IDLE;
            r_step      <= '0;
            r_fin_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_mode      <= n_mode;
            r_step      <= n_step;
            r_fin_pend  <= n_fin_pend;
            r_out_valid <= n_out_valid;
        end
    end

    `BSHL_ASSERT(a_fill_range, i_clk, i_rst_n, r_fill <= BLOCK_BYTES, "block fill above 12")
    `BSHL_ASSERT(a_pend_not_final, i_clk, i_rst_n, r_fin_pend |-> r_mode != MIX_FINAL, "final pending while final rounds run")
    `BSHL_ASSERT(a_block_step, i_clk, i_rst_n, (r_mode == MIX_BLOCK) |-> (r_step <= BLOCK_LAST_STEP), "block round count overrun")
    `BSHL_ASSERT(a_result_after_final, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_mode == MIX_FINAL), "result word without final rounds")

endmodule

### rtl/core/byte_stream_hash_little_endian.sv
// Top level of the streaming little-endian lookup3 byte hash.
// Instantiates bshl_front, bshl_queue and bshl_back; uses bshl_pkg.
//
//  channel   direction  handshake                   word
//  cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_data (seed)
//  in        in         i_in_valid  / o_in_stall    i_in_word (byte, first, last, length)
//  out       out        o_out_valid / i_out_stall   o_out_word (hash, length mismatch)
//
// Inside a message one byte is taken per cycle while the queue is not full; the six
// block rounds run on the shared round unit while the next block fills, so long
// messages keep full rate. Closing a message takes a fold-in plus seven final rounds
// in the back end; the command queue lets the front keep taking bytes meanwhile.
// Synchronous active-low reset clears all control state; no clearing pass.
// The result word is held in an output register until the sink drops stall.
module byte_stream_hash_little_endian #(
    parameter int QUEUE_DEPTH = bshl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  bshl_pkg::t_word     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bshl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bshl_pkg::t_out_word o_out_word
);
    import bshl_pkg::*;

    logic q_push, q_full, q_valid, q_pop;
    t_cmd q_in_cmd, q_head;

    // The seed register always takes a write.
    assign o_cfg_ready = 1'b1;

    bshl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (q_push),
        .o_cmd       (q_in_cmd)
    );

    bshl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    bshl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_head),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
